/* hw/rtl/lfu_pkg.sv */
// lfu_pkg: shared constants and codes for the lfu cache replacement block
// used by lfu_entry_ram and lfu_cache_replacement_top; depends on nothing

package lfu_pkg;

   // default geometry
   localparam int ENTRIES_DEF    = 16;
   localparam int COUNT_BITS_DEF = 16;

   // fixed field widths
   localparam int KEY_W = 32;
   localparam int CAP_W = 5;

   // capacity register after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request opcodes
   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

endpackage

/* hw/rtl/lfu_entry_ram.sv */
// lfu_entry_ram: single write port, single registered read port entry store
// depends on lfu_pkg for default sizes

module lfu_entry_ram #(
   parameter int DEPTH = lfu_pkg::ENTRIES_DEF,
   parameter int WIDTH = 2 * lfu_pkg::KEY_W,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lfu_cache_replacement_top.sv */
// lfu_cache_replacement_top: key/value store with lfu replacement, lru tiebreak
// depends on lfu_pkg and lfu_entry_ram
// sequence: a get hit goes through scan, decide, update and the response load; a get miss
//   skips update; a put returns to idle after update or, when nothing is written, after decide
// one request at a time: a new one is taken only in idle; scan and update each sweep the
//   single read and write port of the entry ram; a get waits in the response load while the
//   previous response is still held
// reset: synchronous, clears valid bits, occupancy, sequencer; capacity returns to 16

module lfu_cache_replacement_top #(
   parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
   parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [2*lfu_pkg::KEY_W-1:0] req_tdata,  // lookup_key, store_value
   input  logic [0:0]                  req_tuser,  // opcode
   // response channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lfu_pkg::KEY_W-1:0]   rsp_tdata,  // read_value
   output logic [0:0]                  rsp_tuser,  // hit
   // capacity register write
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lfu_pkg::CAP_W-1:0]   csr_data
);

   localparam int KEY_W = lfu_pkg::KEY_W;
   localparam int CAP_W = lfu_pkg::CAP_W;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [KEY_W-1:0]      value;
      logic [COUNT_BITS-1:0] count;
      logic [IDX_W-1:0]      rank;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_UPDATE = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      UPD_TOUCH  = 2'b01,
      UPD_INSERT = 2'b10
   } upd_type;

   // sequencer and bookkeeping
   state_type             state_ff, state_in;
   upd_type               mode_ff, mode_in;
   logic [CNT_W-1:0]      step_ff, step_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [CAP_W-1:0]      capacity_ff, capacity_in;

   // latched request
   lfu_pkg::opcode_type   op_ff, op_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [KEY_W-1:0]      val_ff, val_in;

   // scan results
   logic                  match_found_ff, match_found_in;
   logic [IDX_W-1:0]      match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]      match_rank_ff, match_rank_in;
   logic [KEY_W-1:0]      match_value_ff, match_value_in;
   logic                  victim_found_ff, victim_found_in;
   logic [IDX_W-1:0]      victim_idx_ff, victim_idx_in;
   logic [COUNT_BITS-1:0] victim_count_ff, victim_count_in;
   logic [IDX_W-1:0]      victim_rank_ff, victim_rank_in;
   logic                  free_found_ff, free_found_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;

   // decision
   logic                  hit_ff, hit_in;
   logic                  evict_ff, evict_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [KEY_W-1:0]      rsp_value_ff, rsp_value_in;

   // ram ports
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   rec_type               ram_wr_rec;
   logic [REC_W-1:0]      ram_rd_data;
   rec_type               rd_rec;

   // derived
   logic [CNT_W-1:0]      step_m1;
   logic [IDX_W-1:0]      proc_idx;
   logic                  last_step;
   logic [CMP_W-1:0]      cap_ext;
   logic [CMP_W-1:0]      cap_eff;
   logic                  cap_nz;
   logic                  store_full;
   logic                  cand_better;

   lfu_entry_ram #(
      .DEPTH  (ENTRIES),
      .WIDTH  (REC_W),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_rec),
      .rd_addr (step_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_rec    = rec_type'(ram_rd_data);
   assign step_m1   = step_ff - CNT_W'(1);
   assign proc_idx  = step_m1[IDX_W-1:0];
   assign last_step = (step_ff == CNT_W'(ENTRIES));

   // effective capacity, clamped to the store size
   assign cap_ext    = CMP_W'(capacity_ff);
   assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign cap_nz     = (capacity_ff != '0);
   assign store_full = (CMP_W'(occ_ff) >= cap_eff);

   // victim compare: lower count wins, equal count goes to the older entry
   assign cand_better = !victim_found_ff || (rd_rec.count < victim_count_ff) ||
                        ((rd_rec.count == victim_count_ff) && (rd_rec.rank > victim_rank_ff));

   // sequencer
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      step_in         = step_ff;
      occ_in          = occ_ff;
      valid_in        = valid_ff;
      capacity_in     = capacity_ff;
      op_in           = op_ff;
      key_in          = key_ff;
      val_in          = val_ff;
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      match_rank_in   = match_rank_ff;
      match_value_in  = match_value_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      victim_count_in = victim_count_ff;
      victim_rank_in  = victim_rank_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      hit_in          = hit_ff;
      evict_in        = evict_ff;
      slot_in         = slot_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_value_in    = rsp_value_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = proc_idx;
      ram_wr_rec      = rd_rec;

      // response register drains independently
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // capacity write
      if (csr_valid) begin
         capacity_in = csr_data;
      end

      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (req_tvalid) begin
               op_in           = lfu_pkg::opcode_type'(req_tuser[0]);
               key_in          = req_tdata[KEY_W-1:0];
               val_in          = req_tdata[2*KEY_W-1:KEY_W];
               match_found_in  = 1'b0;
               victim_found_in = 1'b0;
               free_found_in   = 1'b0;
               state_in        = S_SCAN;
            end
         end

         // one entry per cycle: key match, victim, first free slot
         S_SCAN: begin
            step_in = step_ff + CNT_W'(1);
            if (step_ff != '0) begin
               if (valid_ff[proc_idx]) begin
                  if (rd_rec.key == key_ff) begin
                     match_found_in = 1'b1;
                     match_idx_in   = proc_idx;
                     match_rank_in  = rd_rec.rank;
                     match_value_in = rd_rec.value;
                  end
                  if (cand_better) begin
                     victim_found_in = 1'b1;
                     victim_idx_in   = proc_idx;
                     victim_count_in = rd_rec.count;
                     victim_rank_in  = rd_rec.rank;
                  end
               end else if (!free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = proc_idx;
               end
            end
            if (last_step) begin
               state_in = S_DECIDE;
            end
         end

         // pick the update to apply
         S_DECIDE: begin
            step_in  = '0;
            evict_in = 1'b0;
            if (op_ff == lfu_pkg::OP_GET) begin
               hit_in = cap_nz && match_found_ff;
               if (cap_nz && match_found_ff) begin
                  mode_in  = UPD_TOUCH;
                  state_in = S_UPDATE;
               end else begin
                  state_in = S_RESP;
               end
            end else if (!cap_nz) begin
               state_in = S_IDLE;
            end else if (match_found_ff) begin
               mode_in  = UPD_TOUCH;
               state_in = S_UPDATE;
            end else begin
               evict_in = store_full && victim_found_ff;
               if (store_full && victim_found_ff &&
                   (!free_found_ff || (victim_idx_ff < free_idx_ff))) begin
                  slot_in = victim_idx_ff;
               end else begin
                  slot_in = free_idx_ff;
               end
               if ((store_full && victim_found_ff) || free_found_ff) begin
                  mode_in  = UPD_INSERT;
                  state_in = S_UPDATE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // read-modify-write sweep over all entries
         S_UPDATE: begin
            step_in = step_ff + CNT_W'(1);
            if (step_ff != '0) begin
               ram_wr_en = 1'b1;
               case (mode_ff)
                  UPD_TOUCH: begin
                     if (proc_idx == match_idx_ff) begin
                        ram_wr_rec.rank = '0;
                        if (rd_rec.count != {COUNT_BITS{1'b1}}) begin
                           ram_wr_rec.count = rd_rec.count + COUNT_BITS'(1);
                        end
                        if (op_ff == lfu_pkg::OP_PUT) begin
                           ram_wr_rec.value = val_ff;
                        end
                     end else if (valid_ff[proc_idx] && (rd_rec.rank < match_rank_ff)) begin
                        ram_wr_rec.rank = rd_rec.rank + IDX_W'(1);
                     end
                  end
                  UPD_INSERT: begin
                     if (proc_idx == slot_ff) begin
                        ram_wr_rec.key   = key_ff;
                        ram_wr_rec.value = val_ff;
                        ram_wr_rec.count = COUNT_BITS'(1);
                        ram_wr_rec.rank  = '0;
                        valid_in[proc_idx] = 1'b1;
                     end else if (evict_ff && (proc_idx == victim_idx_ff)) begin
                        valid_in[proc_idx] = 1'b0;
                     end else if (valid_ff[proc_idx]) begin
                        if (evict_ff && (rd_rec.rank > victim_rank_ff)) begin
                           ram_wr_rec.rank = rd_rec.rank;
                        end else begin
                           ram_wr_rec.rank = rd_rec.rank + IDX_W'(1);
                        end
                     end
                  end
                  default: begin
                     ram_wr_en = 1'b0;
                  end
               endcase
            end
            if (last_step) begin
               if ((mode_ff == UPD_INSERT) && !evict_ff) begin
                  occ_in = occ_ff + CNT_W'(1);
               end
               if (op_ff == lfu_pkg::OP_GET) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // load the response register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_value_in = hit_ff ? match_value_ff : {KEY_W{1'b1}};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         occ_ff       <= '0;
         valid_ff     <= '0;
         capacity_ff  <= lfu_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         occ_ff       <= occ_in;
         valid_ff     <= valid_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      op_ff           <= op_in;
      key_ff          <= key_in;
      val_ff          <= val_in;
      match_found_ff  <= match_found_in;
      match_idx_ff    <= match_idx_in;
      match_rank_ff   <= match_rank_in;
      match_value_ff  <= match_value_in;
      victim_found_ff <= victim_found_in;
      victim_idx_ff   <= victim_idx_in;
      victim_count_ff <= victim_count_in;
      victim_rank_ff  <= victim_rank_in;
      free_found_ff   <= free_found_in;
      free_idx_ff     <= free_idx_in;
      hit_ff          <= hit_in;
      evict_ff        <= evict_in;
      slot_ff         <= slot_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_value_ff    <= rsp_value_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_hit_ff;

`ifndef SYNTHESIS
   // occupancy agrees with the valid bits between items
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == int'(occ_ff)))
      else $error("occupancy does not match valid bits");

   // occupancy never exceeds the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      (int'(occ_ff) <= ENTRIES))
      else $error("occupancy above store size");

   // an evicted victim is a live entry
   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_UPDATE) && (mode_ff == UPD_INSERT) && evict_ff && (step_ff == '0))
      |-> valid_ff[victim_idx_ff])
      else $error("victim entry not valid");

   // a pending response is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_RESP) && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_RESP))
      else $error("response register overwritten");
`endif

endmodule
